// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/lpt_pkg.sv -----
// Types, codes and sizes of the presence table with expiry.
// No dependencies; used by every module of the block.
package lpt_pkg;

  localparam int CAPACITY = 32;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 32;
  localparam int TO_W     = 17;
  localparam int CNT_W    = 6;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 17'd300;

  // Register index, taken from the word address bit.
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [1:0] CMD_ONLINE  = 2'd0;
  localparam logic [1:0] CMD_OFFLINE = 2'd1;
  localparam logic [1:0] CMD_EXPIRE  = 2'd2;

  localparam logic [1:0] KIND_ONLINE  = 2'd0;
  localparam logic [1:0] KIND_OFFLINE = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD  = 3'd0;
  localparam cell_op_t CELL_LOAD  = 3'd1;
  localparam cell_op_t CELL_LEFT  = 3'd2;
  localparam cell_op_t CELL_RIGHT = 3'd3;
  localparam cell_op_t CELL_CLEAR = 3'd4;

  localparam logic [1:0] ACT_TOUCH  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_POP    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   user_id;
    logic [TIME_W-1:0] now;
  } lpt_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  out_id;
    logic             added;
    logic             found;
    logic             full_res;
    logic [CNT_W-1:0] entries;
    logic             last;
  } lpt_out_t;

  typedef struct packed {
    logic       en;
    logic [1:0] act;
  } lpt_chain_ctl_t;

  typedef struct packed {
    logic            hit;
    logic            back_exp;
    logic [ID_W-1:0] back_id;
  } lpt_chain_sts_t;

endpackage

// ----- hw/rtl/lpt_cell.sv -----
// One table position: id, stamp and valid bit, with its own id compare and age test.
// Depends on lpt_pkg.
module lpt_cell
  import lpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_op_t          op,
  input  logic [ID_W-1:0]   key,
  input  logic [TIME_W-1:0] now,
  input  logic [TO_W-1:0]   timeout,
  input  logic [ID_W-1:0]   left_id,
  input  logic [TIME_W-1:0] left_stamp,
  input  logic              left_valid,
  input  logic [ID_W-1:0]   right_id,
  input  logic [TIME_W-1:0] right_stamp,
  input  logic              right_valid,
  output logic [ID_W-1:0]   id,
  output logic [TIME_W-1:0] stamp,
  output logic              valid,
  output logic              match,
  output logic              expired
);

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] age;

  always_comb begin
    id_nxt    = id_r;
    stamp_nxt = stamp_r;
    valid_nxt = valid_r;
    case (op)
      CELL_LOAD: begin
        id_nxt    = key;
        stamp_nxt = now;
        valid_nxt = 1'b1;
      end
      CELL_LEFT: begin
        id_nxt    = left_id;
        stamp_nxt = left_stamp;
        valid_nxt = left_valid;
      end
      CELL_RIGHT: begin
        id_nxt    = right_id;
        stamp_nxt = right_stamp;
        valid_nxt = right_valid;
      end
      CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    stamp_r <= stamp_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The age wraps modulo 2^32.
  assign age     = now - stamp_r;
  assign match   = valid_r && (id_r == key);
  assign expired = valid_r && (age >= {{(TIME_W-TO_W){1'b0}}, timeout});

  assign id    = id_r;
  assign stamp = stamp_r;
  assign valid = valid_r;

endmodule

// ----- hw/rtl/lpt_chain.sv -----
// Row of table cells in recency order, front at position 0, and the per-cell steering.
// Depends on lpt_pkg and lpt_cell.
module lpt_chain
  import lpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lpt_chain_ctl_t    ctl,
  input  logic [ID_W-1:0]   key,
  input  logic [TIME_W-1:0] now,
  input  logic [TO_W-1:0]   timeout,
  output lpt_chain_sts_t    sts
);

  logic [ID_W-1:0]   id_a    [CAPACITY];
  logic [TIME_W-1:0] stamp_a [CAPACITY];
  logic [CAPACITY-1:0] valid_v, match_v, exp_v, back_v;
  logic [CAPACITY-1:0] suf_hit, pre_hit;
  cell_op_t          op_a    [CAPACITY];
  logic [ID_W-1:0]   back_sel;

  // Ids are unique among valid cells, so at most one cell matches.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      suf_hit[i] = |(match_v >> i);
      pre_hit[i] = |(match_v << (CAPACITY - 1 - i));
    end
  end

  // Valid cells form a prefix; the back cell is the last valid one.
  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      back_v[i] = valid_v[i] && !valid_v[i+1];
    end
    back_v[CAPACITY-1] = valid_v[CAPACITY-1];
  end

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_sel = back_sel | (id_a[i] & {ID_W{back_v[i]}});
    end
  end

  assign sts.hit      = |match_v;
  assign sts.back_exp = |(back_v & exp_v);
  assign sts.back_id  = back_sel;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_W-1:0]   l_id, r_id;
      logic [TIME_W-1:0] l_stamp, r_stamp;
      logic              l_valid, r_valid;

      if (g == 0) begin : g_front
        assign l_id    = '0;
        assign l_stamp = '0;
        assign l_valid = 1'b0;
      end else begin : g_mid_l
        assign l_id    = id_a[g-1];
        assign l_stamp = stamp_a[g-1];
        assign l_valid = valid_v[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign r_id    = '0;
        assign r_stamp = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_id    = id_a[g+1];
        assign r_stamp = stamp_a[g+1];
        assign r_valid = valid_v[g+1];
      end

      always_comb begin
        op_a[g] = CELL_HOLD;
        if (ctl.en) begin
          case (ctl.act)
            ACT_TOUCH: begin
              if (g == 0) begin
                op_a[g] = CELL_LOAD;
              end else if (suf_hit[g]) begin
                op_a[g] = CELL_LEFT;
              end
            end
            ACT_INSERT: begin
              if (g == 0) begin
                op_a[g] = CELL_LOAD;
              end else if (l_valid) begin
                op_a[g] = CELL_LEFT;
              end
            end
            ACT_REMOVE: begin
              if (pre_hit[g]) begin
                op_a[g] = CELL_RIGHT;
              end
            end
            ACT_POP: begin
              if (back_v[g]) begin
                op_a[g] = CELL_CLEAR;
              end
            end
            default: begin
              op_a[g] = CELL_HOLD;
            end
          endcase
        end
      end

      lpt_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op_a[g]),
        .key         (key),
        .now         (now),
        .timeout     (timeout),
        .left_id     (l_id),
        .left_stamp  (l_stamp),
        .left_valid  (l_valid),
        .right_id    (r_id),
        .right_stamp (r_stamp),
        .right_valid (r_valid),
        .id          (id_a[g]),
        .stamp       (stamp_a[g]),
        .valid       (valid_v[g]),
        .match       (match_v[g]),
        .expired     (exp_v[g])
      );
    end
  endgenerate

endmodule

// ----- hw/rtl/lru_presence_table_with_expiry_unit.sv -----
// Presence table of up to 32 unique user ids in recency order, each with a
// time stamp, plus a sequencer, the result register and the timeout register.
// An item is taken in the idle state and executed in the exec state. An expire
// scan pops one entry from the back of the cell row per cycle while the result
// slot is free, with one result per expired id and a closing done result.
// Every id compare and age test is done in parallel, one per cell. A result
// that is not taken stalls execution, but the next item is still taken while
// the previous result waits. Depends on lpt_pkg, lpt_chain and lpt_cell.
module lru_presence_table_with_expiry_unit
  import lpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpt_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpt_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r, state_nxt;
  lpt_in_t          item_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TO_W-1:0]  timeout_r;
  logic             out_valid_r, out_valid_nxt;
  lpt_out_t         out_r, out_nxt;

  lpt_chain_ctl_t   chain_ctl;
  lpt_chain_sts_t   chain_sts;
  logic             slot_free, full, emit;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign full      = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    chain_ctl.en  = 1'b0;
    chain_ctl.act = ACT_TOUCH;
    emit          = 1'b0;
    out_nxt       = out_r;

    if (state_r == ST_IDLE) begin
      if (in_valid) begin
        state_nxt = ST_EXEC;
      end
    end else if (slot_free) begin
      out_nxt          = '0;
      out_nxt.out_id   = item_r.user_id;
      out_nxt.last     = 1'b1;
      case (item_r.cmd)
        CMD_ONLINE: begin
          emit         = 1'b1;
          state_nxt    = ST_IDLE;
          out_nxt.kind = KIND_ONLINE;
          if (chain_sts.hit) begin
            chain_ctl.en  = 1'b1;
            chain_ctl.act = ACT_TOUCH;
          end else if (full) begin
            out_nxt.full_res = 1'b1;
          end else begin
            chain_ctl.en  = 1'b1;
            chain_ctl.act = ACT_INSERT;
            cnt_nxt       = cnt_r + 1'b1;
            out_nxt.added = 1'b1;
          end
          out_nxt.entries = cnt_nxt;
        end
        CMD_OFFLINE: begin
          emit         = 1'b1;
          state_nxt    = ST_IDLE;
          out_nxt.kind = KIND_OFFLINE;
          if (chain_sts.hit) begin
            chain_ctl.en  = 1'b1;
            chain_ctl.act = ACT_REMOVE;
            cnt_nxt       = cnt_r - 1'b1;
            out_nxt.found = 1'b1;
          end
          out_nxt.entries = cnt_nxt;
        end
        CMD_EXPIRE: begin
          emit = 1'b1;
          if (chain_sts.back_exp) begin
            chain_ctl.en   = 1'b1;
            chain_ctl.act  = ACT_POP;
            cnt_nxt        = cnt_r - 1'b1;
            out_nxt.kind   = KIND_EXPIRED;
            out_nxt.out_id = chain_sts.back_id;
            out_nxt.last   = 1'b0;
          end else begin
            state_nxt      = ST_IDLE;
            out_nxt.kind   = KIND_DONE;
            out_nxt.out_id = '0;
          end
          out_nxt.entries = cnt_nxt;
        end
        default: begin
          // The unused command produces nothing.
          state_nxt = ST_IDLE;
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && (cfg_paddr[CFG_AW-1] == REG_TIMEOUT)) begin
        timeout_r <= cfg_pwdata[TO_W-1:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_TIMEOUT)
                      ? {{(CFG_DW-TO_W){1'b0}}, timeout_r} : '0;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  lpt_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (chain_ctl),
    .key     (item_r.user_id),
    .now     (item_r.now),
    .timeout (timeout_r),
    .sts     (chain_sts)
  );

endmodule

// ----- hw/rtl/lpt_checker.sv -----
// Port-level checks for the presence table, attached to the top level by bind.
// Depends on lpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpt_checker
  import lpt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input lpt_out_t out_data,
  input logic     cfg_pready
);

  // A result that is not taken holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // One item is worked on at a time: no transfer in the cycle after one.
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // Only expired-id results leave the scan open.
  `ASSERT_IMPLY(a_last_kind, clk, rst_n, out_valid,
                out_data.last == (out_data.kind != KIND_EXPIRED))

  `ASSERT_IMPLY(a_entries_max, clk, rst_n, out_valid, out_data.entries <= CNT_W'(CAPACITY))

  // A refused insert only happens on a full table.
  `ASSERT_IMPLY(a_full_res, clk, rst_n, out_valid && out_data.full_res,
                out_data.kind == KIND_ONLINE && !out_data.added
                && out_data.entries == CNT_W'(CAPACITY) && cfg_pready)

endmodule

bind lru_presence_table_with_expiry_unit lpt_checker u_lpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
